### hdl/mcs_pkg.sv
// Package with the shared types and constants of the motor command sequencer.
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int US_W    = 17;
  localparam int LOOP_W  = 16;
  localparam int CODE_W  = 6;
  localparam int MASK_W  = 8;
  localparam int REP_W   = 8;
  localparam int NUM_W   = US_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);
  localparam int IN_W    = 40;
  localparam int OUT_W   = 24;
  localparam logic [LOOP_W-1:0] LOOP_TIME_RESET = 16'd125;

  typedef enum logic [1:0] {
    PH_IDLEWAIT = 2'd0,
    PH_START    = 2'd1,
    PH_ACTIVE   = 2'd2,
    PH_POST     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DEST_START = 2'd0,
    DEST_GAP   = 2'd1,
    DEST_POST  = 2'd2
  } dest_t;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

endpackage

### hdl/motor_command_sequencer_top.sv
// Top level of the motor command sequencer: command ring, sequencer and serial divider.
`timescale 1ns / 1ps

// The block takes one request on the s_axis channel and returns one result on the
// m_axis channel. tuser selects a tick of the motor loop or the enqueueing of a
// command; a tick result says whether motor output may go out in this loop cycle.
// The cfg channel writes the loop period in microseconds and is always ready; it
// should only be written while the block is idle.
// A request that needs no delay conversion goes from acceptance through the execute
// and done states to the result. One that turns a delay into loop cycles also uses
// the shared restoring divider, one quotient bit per cycle, and the write-back state.
// The block works on one request at a time; s_axis_tready is high only between
// requests, and a new request can be accepted as soon as a result is presented.
// A finished result is held in the output register while the receiver
// stalls, and the next request may be accepted meanwhile; that request then
// waits before the output register until the previous result has been taken.
// Reset empties the ring, sets every entry to idle-wait and loads a loop period
// of 125 microseconds; no clearing pass is needed.
module motor_command_sequencer_top
  import mcs_pkg::*;
#(
  parameter int QUEUE_CAPACITY = 3,
  parameter int MOTOR_COUNT    = 8,
  parameter int START_DELAY_US = 10000,
  parameter int REPEAT_GAP_US  = 1000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // all_motors_idle, command_code, motor_mask, repeat_count, post_delay_us
  input  logic [IN_W-1:0]   s_axis_tdata,
  // operation
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // output_enabled, command_processing, queue_empty, enqueue_accepted,
  // current_command, current_motor_mask, zero fill
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LOOP_W-1:0] cfg_data
);

  localparam int SLOTS = QUEUE_CAPACITY + 1;
  localparam int PTR_W = $clog2(SLOTS);
  localparam logic [MASK_W-1:0] MOTOR_BITS = MASK_W'((1 << MOTOR_COUNT) - 1);
  localparam logic [US_W-1:0] START_US = US_W'(START_DELAY_US);
  localparam logic [US_W-1:0] GAP_US   = US_W'(REPEAT_GAP_US);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  state_t state;

  logic [LOOP_W-1:0] loop_time_us;
  phase_t            entry_phase     [SLOTS];
  logic [US_W-1:0]   entry_countdown [SLOTS];
  logic [REP_W-1:0]  entry_repeats   [SLOTS];
  logic [US_W-1:0]   entry_post_delay[SLOTS];
  logic [CODE_W-1:0] entry_code      [SLOTS];
  logic [MASK_W-1:0] entry_mask      [SLOTS];
  logic [PTR_W-1:0]  head_pointer;
  logic [PTR_W-1:0]  tail_pointer;

  logic              req_op;
  logic [IN_W-1:0]   req_data;
  logic              enabled;
  logic              accepted;

  dest_t             div_dest;
  logic [NUM_W-1:0]  div_num;
  logic [US_W-1:0]   div_quo;
  logic [LOOP_W-1:0] div_rem;
  logic [STEP_W-1:0] div_step;

  logic [LOOP_W-1:0] lt_eff;
  logic [LOOP_W:0]   trial;
  logic              trial_ge;
  logic [PTR_W-1:0]  head_succ;
  logic [PTR_W-1:0]  tail_succ;
  logic              is_empty;
  logic              head_is_last;
  logic [REP_W-1:0]  rep_dec;
  phase_t            head_phase;
  logic              processing;
  logic              out_free;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [NUM_W-1:0] ceil_num(input logic [US_W-1:0] us,
                                               input logic [LOOP_W-1:0] lt);
    ceil_num = {1'b0, us} + {{(NUM_W-LOOP_W){1'b0}}, lt} - NUM_W'(1);
  endfunction

  assign lt_eff       = (loop_time_us == '0) ? LOOP_W'(1) : loop_time_us;
  assign trial        = {div_rem, div_num[NUM_W-1]};
  assign trial_ge     = trial >= {1'b0, lt_eff};
  assign head_succ    = ring_next(head_pointer);
  assign tail_succ    = ring_next(tail_pointer);
  assign is_empty     = head_pointer == tail_pointer;
  assign head_is_last = head_succ == tail_pointer;
  assign rep_dec      = entry_repeats[head_pointer] - REP_W'(1);
  assign head_phase   = entry_phase[head_pointer];
  assign processing   = !is_empty && (head_phase == PH_START || head_phase == PH_ACTIVE ||
                        (head_phase == PH_POST && !head_is_last));
  assign out_free     = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = state == S_IDLE;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loop_time_us  <= LOOP_TIME_RESET;
      head_pointer  <= '0;
      tail_pointer  <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        entry_phase[i]     <= PH_IDLEWAIT;
        entry_countdown[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        loop_time_us <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_op   <= s_axis_tuser;
            req_data <= s_axis_tdata;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          enabled  <= 1'b0;
          accepted <= 1'b0;
          state    <= S_DONE;
          div_rem  <= '0;
          div_step <= '0;
          if (req_op == OP_ENQUEUE) begin
            if (tail_succ != head_pointer) begin
              entry_phase[tail_pointer]      <= PH_IDLEWAIT;
              entry_countdown[tail_pointer]  <= '0;
              entry_code[tail_pointer]       <= req_data[6:1];
              entry_mask[tail_pointer]       <= req_data[14:7] & MOTOR_BITS;
              entry_repeats[tail_pointer]    <= req_data[22:15];
              entry_post_delay[tail_pointer] <= req_data[39:23];
              tail_pointer                   <= tail_succ;
              accepted                       <= 1'b1;
            end
          end else if (is_empty) begin
            enabled <= 1'b1;
          end else begin
            case (head_phase)
              PH_IDLEWAIT: begin
                enabled <= 1'b1;
                if (req_data[0]) begin
                  entry_phase[head_pointer] <= PH_START;
                  div_num  <= ceil_num(START_US, lt_eff);
                  div_dest <= DEST_START;
                  state    <= S_DIV;
                end
              end
              PH_START, PH_ACTIVE: begin
                if (entry_countdown[head_pointer] != '0) begin
                  entry_countdown[head_pointer] <= entry_countdown[head_pointer] - US_W'(1);
                end else begin
                  enabled <= 1'b1;
                  entry_phase[head_pointer]   <= PH_ACTIVE;
                  entry_repeats[head_pointer] <= rep_dec;
                  state <= S_DIV;
                  if (rep_dec != '0) begin
                    div_num  <= ceil_num(GAP_US, lt_eff);
                    div_dest <= DEST_GAP;
                  end else begin
                    entry_phase[head_pointer] <= PH_POST;
                    div_num  <= ceil_num(entry_post_delay[head_pointer], lt_eff);
                    div_dest <= DEST_POST;
                  end
                end
              end
              default: begin
                if (entry_countdown[head_pointer] != '0) begin
                  entry_countdown[head_pointer] <= entry_countdown[head_pointer] - US_W'(1);
                end else begin
                  head_pointer <= head_succ;
                  if (head_succ != tail_pointer) begin
                    entry_phase[head_succ]     <= PH_ACTIVE;
                    entry_countdown[head_succ] <= '0;
                  end else begin
                    enabled <= 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_DIV: begin
          if (trial_ge) begin
            div_rem <= LOOP_W'(trial - {1'b0, lt_eff});
          end else begin
            div_rem <= trial[LOOP_W-1:0];
          end
          div_quo  <= {div_quo[US_W-2:0], trial_ge};
          div_num  <= {div_num[NUM_W-2:0], 1'b0};
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (div_dest == DEST_POST && !head_is_last && div_quo != '0) begin
            entry_countdown[head_pointer] <= div_quo - US_W'(1);
          end else begin
            entry_countdown[head_pointer] <= div_quo;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'b0,
                              is_empty ? {MASK_W{1'b0}} : entry_mask[head_pointer],
                              is_empty ? {CODE_W{1'b0}} : entry_code[head_pointer],
                              accepted, is_empty, processing, enabled};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
